FILE: design/mlpq_pkg.sv
`timescale 1ns / 1ps

package mlpq_pkg;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam logic [1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [1:0] STAT_DEQUEUED = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic        action;
        logic [31:0] value;
        logic [2:0]  level;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_value;
        logic [2:0]  out_level;
        logic        any_waiting;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_DQ_HEAD,
        ST_DQ_FIN,
        ST_REPLY
    } t_state;

endpackage

FILE: design/mlpq_ram.sv
`timescale 1ns / 1ps

module mlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/multilevel_priority_queue_pool.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_in_data  (t_in_req)
// output    out        o_out_valid / i_out_stall    o_out_data (t_out_req)
//
// An enqueue reads the level tail and the free node's link together, then links the node in.
// A dequeue reads the level head, then the head node's link. Full or empty goes straight to the reply state.
// One request is worked at a time; the next is accepted once the result is registered.
// Reset needs no clearing pass: untouched nodes are tracked by a fill count.
// A stalled result holds the final step until the output register frees.

module multilevel_priority_queue_pool
    import mlpq_pkg::*;
#(
    parameter int LEVELS     = 8,
    parameter int POOL_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    localparam int LW  = $clog2(LEVELS);
    localparam int PW  = $clog2(POOL_DEPTH);
    localparam int CW  = $clog2(POOL_DEPTH + 1);
    localparam int LXW = (LW > 3) ? LW : 3;

    t_state              r_state, n_state;
    logic [LEVELS-1:0]   r_nonempty, n_nonempty;
    logic [PW-1:0]       r_free_head, n_free_head;
    logic [CW-1:0]       r_free_count, n_free_count;
    logic [CW-1:0]       r_fresh_cnt, n_fresh_cnt;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [PW-1:0]       r_node, n_node;
    logic [1:0]          r_reply, n_reply;
    t_out_req            r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic [LW-1:0]       enq_lvl;
    logic [LXW-1:0]      enq_lvl_x;
    logic [LW-1:0]       deq_lvl;
    logic                fresh;
    logic [PW-1:0]       node_next;
    logic                is_last;

    logic                link_wr_en, link_rd_en;
    logic [PW-1:0]       link_wr_addr, link_wr_data, link_rd_addr, link_rd_data;
    logic                pay_wr_en, pay_rd_en;
    logic [PW-1:0]       pay_wr_addr, pay_rd_addr;
    logic [DATA_WIDTH-1:0] pay_wr_data, pay_rd_data;
    logic                head_wr_en, head_rd_en;
    logic [LW-1:0]       head_wr_addr, head_rd_addr;
    logic [PW-1:0]       head_wr_data, head_rd_data;
    logic                tail_wr_en, tail_rd_en;
    logic [LW-1:0]       tail_wr_addr, tail_rd_addr;
    logic [PW-1:0]       tail_wr_data, tail_rd_data;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign enq_lvl_x = LXW'(i_in_data.level);
    assign enq_lvl   = (enq_lvl_x > LXW'(LEVELS - 1)) ? LW'(LEVELS - 1) : LW'(enq_lvl_x);

    always_comb begin
        deq_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                deq_lvl = LW'(i);
            end
        end
    end

    assign fresh     = (CW'(r_free_head) == r_fresh_cnt);
    assign node_next = (r_free_head == PW'(POOL_DEPTH - 1)) ? '0 : r_free_head + 1'b1;
    assign is_last   = (r_node == tail_rd_data);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.action == ACT_ENQUEUE) begin
                        n_state = (r_free_count == '0) ? ST_REPLY : ST_ENQ;
                    end else begin
                        n_state = (r_nonempty == '0) ? ST_REPLY : ST_DQ_HEAD;
                    end
                end
            end
            ST_ENQ: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DQ_HEAD: begin
                n_state = ST_DQ_FIN;
            end
            ST_DQ_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_nonempty   = r_nonempty;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_fresh_cnt  = r_fresh_cnt;
        n_lvl        = r_lvl;
        n_node       = r_node;
        n_reply      = r_reply;
        n_out        = r_out;
        out_load     = 1'b0;

        link_wr_en   = 1'b0;
        link_wr_addr = tail_rd_data;
        link_wr_data = r_free_head;
        link_rd_en   = 1'b0;
        link_rd_addr = r_free_head;
        pay_wr_en    = 1'b0;
        pay_wr_addr  = r_free_head;
        pay_wr_data  = DATA_WIDTH'(i_in_data.value);
        pay_rd_en    = 1'b0;
        pay_rd_addr  = head_rd_data;
        head_wr_en   = 1'b0;
        head_wr_addr = r_lvl;
        head_wr_data = r_free_head;
        head_rd_en   = 1'b0;
        head_rd_addr = deq_lvl;
        tail_wr_en   = 1'b0;
        tail_wr_addr = r_lvl;
        tail_wr_data = r_free_head;
        tail_rd_en   = 1'b0;
        tail_rd_addr = enq_lvl;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.action == ACT_ENQUEUE) begin
                        n_lvl   = enq_lvl;
                        n_reply = STAT_FULL;
                        if (r_free_count != '0) begin
                            tail_rd_en = 1'b1;
                            link_rd_en = 1'b1;
                            pay_wr_en  = 1'b1;
                        end
                    end else begin
                        n_lvl        = deq_lvl;
                        n_reply      = STAT_EMPTY;
                        tail_rd_addr = deq_lvl;
                        if (r_nonempty != '0) begin
                            head_rd_en = 1'b1;
                            tail_rd_en = 1'b1;
                        end
                    end
                end
            end
            ST_ENQ: begin
                if (out_free) begin
                    if (r_nonempty[r_lvl]) begin
                        link_wr_en = 1'b1;
                    end else begin
                        head_wr_en = 1'b1;
                    end
                    tail_wr_en        = 1'b1;
                    n_nonempty[r_lvl] = 1'b1;
                    if (fresh) begin
                        n_free_head = node_next;
                        n_fresh_cnt = r_fresh_cnt + 1'b1;
                    end else begin
                        n_free_head = link_rd_data;
                    end
                    n_free_count      = r_free_count - 1'b1;
                    n_out.status      = STAT_ENQUEUED;
                    n_out.out_value   = '0;
                    n_out.out_level   = '0;
                    n_out.any_waiting = 1'b1;
                    out_load          = 1'b1;
                end
            end
            ST_DQ_HEAD: begin
                n_node       = head_rd_data;
                link_rd_en   = 1'b1;
                link_rd_addr = head_rd_data;
                pay_rd_en    = 1'b1;
            end
            ST_DQ_FIN: begin
                if (out_free) begin
                    if (is_last) begin
                        n_nonempty[r_lvl] = 1'b0;
                    end else begin
                        head_wr_en   = 1'b1;
                        head_wr_data = link_rd_data;
                    end
                    link_wr_en   = 1'b1;
                    link_wr_addr = r_node;
                    link_wr_data = r_free_head;
                    n_free_head  = r_node;
                    if (r_free_count < CW'(POOL_DEPTH)) begin
                        n_free_count = r_free_count + 1'b1;
                    end
                    n_out.status      = STAT_DEQUEUED;
                    n_out.out_value   = 32'(pay_rd_data);
                    n_out.out_level   = 3'(r_lvl);
                    n_out.any_waiting = (n_nonempty != '0);
                    out_load          = 1'b1;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    n_out.status      = r_reply;
                    n_out.out_value   = '0;
                    n_out.out_level   = '0;
                    n_out.any_waiting = (r_nonempty != '0);
                    out_load          = 1'b1;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_nonempty   <= '0;
            r_free_head  <= '0;
            r_free_count <= CW'(POOL_DEPTH);
            r_fresh_cnt  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nonempty   <= n_nonempty;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_fresh_cnt  <= n_fresh_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl   <= n_lvl;
        r_node  <= n_node;
        r_reply <= n_reply;
        r_out   <= n_out;
    end

    mlpq_ram #(
        .WIDTH(PW),
        .DEPTH(POOL_DEPTH)
    ) u_link_ram (
        .i_clk    (i_clk),
        .i_wr_en  (link_wr_en),
        .i_wr_addr(link_wr_addr),
        .i_wr_data(link_wr_data),
        .i_rd_en  (link_rd_en),
        .i_rd_addr(link_rd_addr),
        .o_rd_data(link_rd_data)
    );

    mlpq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(POOL_DEPTH)
    ) u_payload_ram (
        .i_clk    (i_clk),
        .i_wr_en  (pay_wr_en),
        .i_wr_addr(pay_wr_addr),
        .i_wr_data(pay_wr_data),
        .i_rd_en  (pay_rd_en),
        .i_rd_addr(pay_rd_addr),
        .o_rd_data(pay_rd_data)
    );

    mlpq_ram #(
        .WIDTH(PW),
        .DEPTH(LEVELS)
    ) u_head_ram (
        .i_clk    (i_clk),
        .i_wr_en  (head_wr_en),
        .i_wr_addr(head_wr_addr),
        .i_wr_data(head_wr_data),
        .i_rd_en  (head_rd_en),
        .i_rd_addr(head_rd_addr),
        .o_rd_data(head_rd_data)
    );

    mlpq_ram #(
        .WIDTH(PW),
        .DEPTH(LEVELS)
    ) u_tail_ram (
        .i_clk    (i_clk),
        .i_wr_en  (tail_wr_en),
        .i_wr_addr(tail_wr_addr),
        .i_wr_data(tail_wr_data),
        .i_rd_en  (tail_rd_en),
        .i_rd_addr(tail_rd_addr),
        .o_rd_data(tail_rd_data)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
